// ===== sv/slt_pkg.sv =====
// shared types, character codes and helpers for the shell line tokenizer
package slt_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_ch;
        logic [2:0] token_type;
        logic       last;
    } out_item_t;

    localparam int unsigned MaxResults = 3;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [2:0] TOK_WORD    = 3'd0;
    localparam logic [2:0] TOK_GREATER = 3'd1;
    localparam logic [2:0] TOK_DLESS   = 3'd2;
    localparam logic [2:0] TOK_CAT     = 3'd3;
    localparam logic [2:0] TOK_ECHO    = 3'd4;
    localparam logic [2:0] TOK_NEWLINE = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_T     = 8'h74;

    // keyword prefix tracker codes
    localparam logic [3:0] KM_EMPTY = 4'd0;
    localparam logic [3:0] KM_C     = 4'd1;
    localparam logic [3:0] KM_CA    = 4'd2;
    localparam logic [3:0] KM_CAT   = 4'd3;
    localparam logic [3:0] KM_E     = 4'd4;
    localparam logic [3:0] KM_EC    = 4'd5;
    localparam logic [3:0] KM_ECH   = 4'd6;
    localparam logic [3:0] KM_ECHO  = 4'd7;
    localparam logic [3:0] KM_NONE  = 4'd8;

    function automatic logic [3:0] km_next(input logic [3:0] km, input logic [7:0] c);
        logic [3:0] nx;
        nx = KM_NONE;
        unique case (km)
            KM_EMPTY: nx = (c == CH_C) ? KM_C : ((c == CH_E) ? KM_E : KM_NONE);
            KM_C:     nx = (c == CH_A) ? KM_CA : KM_NONE;
            KM_CA:    nx = (c == CH_T) ? KM_CAT : KM_NONE;
            KM_E:     nx = (c == CH_C) ? KM_EC : KM_NONE;
            KM_EC:    nx = (c == CH_H) ? KM_ECH : KM_NONE;
            KM_ECH:   nx = (c == CH_O) ? KM_ECHO : KM_NONE;
            default:  nx = KM_NONE;
        endcase
        return nx;
    endfunction

    function automatic out_item_t mk_text(input logic [7:0] c);
        out_item_t r;
        r.kind       = KIND_TEXT;
        r.text_ch    = c;
        r.token_type = TOK_WORD;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic out_item_t mk_end(input logic [2:0] t);
        out_item_t r;
        r.kind       = KIND_END;
        r.text_ch    = CH_NUL;
        r.token_type = t;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    endfunction

endpackage

// ===== sv/shell_line_tokenizer_top.sv =====
// shell line tokenizer: input register, single-pass lexer, result buffer
//
//   channel | ports                       | payload    | per item
//   --------+-----------------------------+------------+-------------------------
//   input   | s_valid, s_ready, s_item    | in_item_t  | one character or line end
//   output  | m_valid, m_ready, m_item    | out_item_t | 0 to 3 results
//
// an item is registered in the input register, then the lexer turns it into
// its results in one pass and loads them into the result buffer
// one item per cycle while m_ready is high and each item gives at most one result;
// an item with n results holds the buffer until all n have left, one per handshake
// an item that gives no result still waits for the buffer to drain, then leaves it empty
// synchronous active-low reset returns the lexer to neutral, empties both stages
module shell_line_tokenizer_top
    import slt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    typedef enum logic [1:0] {
        MODE_NEUTRAL,
        MODE_LT,
        MODE_QUOTE,
        MODE_WORD
    } mode_t;

    logic      in_valid_reg;
    in_item_t  in_reg;

    mode_t      mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic [3:0] km_reg, km_next_val;

    out_item_t  res_reg [MaxResults];
    out_item_t  res_next [MaxResults];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg;

    logic       take, done, buf_free, move;
    logic       redo;
    logic [7:0] c;

    assign take     = m_valid && m_ready;
    assign done     = take && (idx_reg == 2'(cnt_reg - 2'd1));
    assign buf_free = (cnt_reg == 2'd0) || done;
    assign move     = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || move;
    assign m_valid  = cnt_reg != 2'd0;
    assign m_item   = res_reg[idx_reg];
    assign c        = in_reg.ch;

    // lexer: results and next state for the item in the input register
    always_comb begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        km_next_val = km_reg;
        cnt_next    = 2'd0;
        redo        = 1'b0;
        for (int i = 0; i < MaxResults; i++) begin
            res_next[i] = mk_end(TOK_WORD);
        end

        if (in_reg.line_end || c == CH_NUL) begin
            mode_next   = MODE_NEUTRAL;
            esc_next    = 1'b0;
            km_next_val = KM_EMPTY;
            res_next[0] = mk_end(TOK_NEWLINE);
            cnt_next    = 2'd1;
        end else begin
            unique case (mode_reg)
                MODE_LT: begin
                    mode_next = MODE_NEUTRAL;
                    if (c == CH_LT) begin
                        res_next[0] = mk_text(c);
                        res_next[1] = mk_end(TOK_DLESS);
                        cnt_next    = 2'd2;
                    end else begin
                        res_next[0] = mk_end(TOK_WORD);
                        cnt_next    = 2'd1;
                        redo        = 1'b1;
                    end
                end
                MODE_QUOTE: begin
                    if (esc_reg) begin
                        esc_next    = 1'b0;
                        res_next[0] = mk_text(c);
                        cnt_next    = 2'd1;
                    end else if (c == CH_BSL) begin
                        esc_next = 1'b1;
                    end else if (c == CH_QUOTE) begin
                        res_next[0] = mk_end(TOK_WORD);
                        cnt_next    = 2'd1;
                        mode_next   = MODE_NEUTRAL;
                    end else begin
                        res_next[0] = mk_text(c);
                        cnt_next    = 2'd1;
                    end
                end
                MODE_WORD: begin
                    if (is_space(c) || c == CH_LT || c == CH_GT || c == CH_QUOTE) begin
                        res_next[0] = mk_end((km_reg == KM_CAT) ? TOK_CAT :
                                             ((km_reg == KM_ECHO) ? TOK_ECHO : TOK_WORD));
                        cnt_next    = 2'd1;
                        mode_next   = MODE_NEUTRAL;
                        km_next_val = KM_EMPTY;
                        redo        = 1'b1;
                    end else begin
                        km_next_val = km_next(km_reg, c);
                        res_next[0] = mk_text(c);
                        cnt_next    = 2'd1;
                    end
                end
                default: begin
                    redo = 1'b1;
                end
            endcase

            // ending character handled again from neutral
            if (redo) begin
                priority if (c == CH_GT) begin
                    res_next[cnt_next]              = mk_text(c);
                    res_next[2'(cnt_next + 2'd1)]   = mk_end(TOK_GREATER);
                    cnt_next                        = 2'(cnt_next + 2'd2);
                    mode_next                       = MODE_NEUTRAL;
                end else if (c == CH_LT) begin
                    res_next[cnt_next] = mk_text(c);
                    cnt_next           = 2'(cnt_next + 2'd1);
                    mode_next          = MODE_LT;
                end else if (is_space(c)) begin
                    mode_next = MODE_NEUTRAL;
                end else if (c == CH_QUOTE) begin
                    mode_next = MODE_QUOTE;
                    esc_next  = 1'b0;
                end else begin
                    mode_next          = MODE_WORD;
                    km_next_val        = km_next(KM_EMPTY, c);
                    res_next[cnt_next] = mk_text(c);
                    cnt_next           = 2'(cnt_next + 2'd1);
                end
            end
        end

        if (cnt_next != 2'd0) begin
            res_next[2'(cnt_next - 2'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_NEUTRAL;
            esc_reg      <= 1'b0;
            km_reg       <= KM_EMPTY;
            cnt_reg      <= 2'd0;
            idx_reg      <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_reg       <= s_item;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end

            if (move) begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                km_reg   <= km_next_val;
                res_reg  <= res_next;
                cnt_reg  <= cnt_next;
                idx_reg  <= 2'd0;
            end else if (done) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else if (take) begin
                idx_reg <= 2'(idx_reg + 2'd1);
            end
        end
    end

`ifndef ASSERT_OFF
    // read pointer stays inside the loaded group
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg < cnt_reg))
        else $error("result index beyond group");

    // last flag marks exactly the final result of the group
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.last == (idx_reg == 2'(cnt_reg - 2'd1))))
        else $error("last flag misplaced");

    // a held item in the input register is neither dropped nor altered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !move) |=> (in_valid_reg && $stable(in_reg)))
        else $error("pending item lost");
`endif

endmodule
